@@ rtl/core/krrl_pkg.sv @@
// key frame request rate limiter: shared types and constants
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package krrl_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = INTERVAL_W'(1000);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLED      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_INTERVAL = CFG_IDX_W'(1);

  // event kinds
  typedef enum logic [OP_W-1:0] {
    OP_LOSS       = 3'd0,
    OP_NEW_VIEWER = 3'd1,
    OP_TIMEOUT    = 3'd2,
    OP_POLL       = 3'd3,
    OP_FRAME      = 3'd4
  } krrl_op_t;

  typedef struct packed {
    logic              enabled;
    logic [INTERVAL_W-1:0] min_interval_ms;
  } krrl_cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TIME_W-1:0] now_ms;
    logic              key_frame;
  } krrl_event_t;

  typedef struct packed {
    logic              grant;
    logic              pending_now;
    logic              pending_later;
    logic [CNT_W-1:0]  request_count;
    logic [CNT_W-1:0]  loss_received_count;
    logic [CNT_W-1:0]  loss_accepted_count;
    logic [CNT_W-1:0]  loss_deferred_count;
    logic [TIME_W-1:0] loss_to_grant_ms;
    logic              loss_to_grant_valid;
    logic [TIME_W-1:0] grant_to_frame_ms;
    logic              grant_to_frame_valid;
  } krrl_result_t;

endpackage

`default_nettype wire

@@ rtl/core/krrl_in_if.sv @@
// event request channel: valid/ready handshake with event payload
// depends on krrl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface krrl_in_if;
  logic                        valid;
  logic                        ready;
  logic [krrl_pkg::OP_W-1:0]   operation;
  logic [krrl_pkg::TIME_W-1:0] now_ms;
  logic                        key_frame;

  modport source (output valid, output operation, output now_ms, output key_frame,
                  input ready);
  modport sink (input valid, input operation, input now_ms, input key_frame,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/krrl_out_if.sv @@
// result request channel: valid/ready handshake with status payload
// depends on krrl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface krrl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        grant;
  logic                        pending_now;
  logic                        pending_later;
  logic [krrl_pkg::CNT_W-1:0]  request_count;
  logic [krrl_pkg::CNT_W-1:0]  loss_received_count;
  logic [krrl_pkg::CNT_W-1:0]  loss_accepted_count;
  logic [krrl_pkg::CNT_W-1:0]  loss_deferred_count;
  logic [krrl_pkg::TIME_W-1:0] loss_to_grant_ms;
  logic                        loss_to_grant_valid;
  logic [krrl_pkg::TIME_W-1:0] grant_to_frame_ms;
  logic                        grant_to_frame_valid;

  modport source (output valid, output grant, output pending_now, output pending_later,
                  output request_count, output loss_received_count,
                  output loss_accepted_count, output loss_deferred_count,
                  output loss_to_grant_ms, output loss_to_grant_valid,
                  output grant_to_frame_ms, output grant_to_frame_valid,
                  input ready);
  modport sink (input valid, input grant, input pending_now, input pending_later,
                input request_count, input loss_received_count,
                input loss_accepted_count, input loss_deferred_count,
                input loss_to_grant_ms, input loss_to_grant_valid,
                input grant_to_frame_ms, input grant_to_frame_valid,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/krrl_cfg_if.sv @@
// configuration write channel: valid/ready with register index and data
// depends on krrl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface krrl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [krrl_pkg::CFG_IDX_W-1:0]  index;
  logic [krrl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/keyframe_request_rate_limiter_unit.sv @@
// Key frame request rate limiter, top level.
//
// Channels: in_req carries events (operation, now_ms, key_frame); out_res
// returns one status request per event: the grant flag for an encoder poll,
// the pending flags, four wrapping counters and the two latency measures.
// cfg_wr writes index 0 (enabled) and index 1 (min_interval_ms); other
// indexes are dropped. cfg_wr.ready is always high. Write configuration
// only while no event is in flight.
// An accepted event waits in the input register, and its result then waits
// in the result register until the receiver takes it.
// Throughput: one event per cycle unless out_res stalls; the limiter state
// is read and rewritten in the same cycle, so consecutive events see each
// other's updates.
// Reset (rst_n low, synchronous) clears both valid flags, all limiter state
// and counters, disables the block and sets the interval to 1000 ms.
// When out_res stalls, the held result stays put, the input register takes
// one more event only if it is empty, and in_req.ready then stays low until
// the receiver takes the result.
// Depends on krrl_pkg, the krrl channel interfaces and krrl_* submodules.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_request_rate_limiter_unit (
  input  logic       clk,
  input  logic       rst_n,
  krrl_in_if.sink    in_req,
  krrl_out_if.source out_res,
  krrl_cfg_if.sink   cfg_wr
);

  krrl_pkg::krrl_cfg_t    cfg;
  krrl_pkg::krrl_event_t  ev;
  krrl_pkg::krrl_result_t res_nxt;
  logic                   ev_valid;
  logic                   out_free;
  logic                   fire;

  // an event moves through the engine when the result register has room
  assign fire = ev_valid && out_free;

  krrl_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  krrl_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .fire     (fire),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  krrl_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .ev      (ev),
    .res_nxt (res_nxt)
  );

  krrl_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .res_nxt (res_nxt),
    .free    (out_free),
    .out_res (out_res)
  );

  // a grant always leaves nothing pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.grant |-> !out_res.pending_now && !out_res.pending_later)
    else $error("grant reported with a request still pending");

  // an event passed to the engine shows up as a result
  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_res.valid)
    else $error("engine update produced no result");

  // a held event is never dropped
  assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid && !fire |=> ev_valid)
    else $error("input register lost an event");

  // the loss to grant measure stays valid once taken
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(res_nxt.loss_to_grant_valid) |-> res_nxt.loss_to_grant_valid)
    else $error("loss to grant measure lost its valid flag");

endmodule

`default_nettype wire

@@ rtl/core/krrl_cfg_regs.sv @@
// configuration registers: enable bit and minimum loss grant interval
// depends on krrl_pkg and krrl_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module krrl_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  krrl_cfg_if.sink            cfg_wr,
  output krrl_pkg::krrl_cfg_t cfg
);

  krrl_pkg::krrl_cfg_t cfg_r;
  krrl_pkg::krrl_cfg_t cfg_nxt;

  // writes are always taken
  assign cfg_wr.ready = 1'b1;

  // decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        krrl_pkg::CFG_IDX_ENABLED:      cfg_nxt.enabled = cfg_wr.data[0];
        krrl_pkg::CFG_IDX_MIN_INTERVAL: cfg_nxt.min_interval_ms = cfg_wr.data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b0;
      cfg_r.min_interval_ms <= krrl_pkg::MIN_INTERVAL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/core/krrl_in_stage.sv @@
// input register: captures one event request, frees when the engine consumes it
// depends on krrl_pkg and krrl_in_if
`timescale 1ns / 1ps
`default_nettype none

module krrl_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  krrl_in_if.sink               in_req,
  input  logic                  fire,
  output logic                  ev_valid,
  output krrl_pkg::krrl_event_t ev
);

  logic                  valid_r;
  logic                  valid_nxt;
  krrl_pkg::krrl_event_t ev_r;
  logic                  take;

  // room when empty or when the held event leaves this cycle
  assign in_req.ready = !valid_r || fire;
  assign take         = in_req.valid && in_req.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      ev_r.operation <= in_req.operation;
      ev_r.now_ms    <= in_req.now_ms;
      ev_r.key_frame <= in_req.key_frame;
    end
  end

  assign ev_valid = valid_r;
  assign ev       = ev_r;

endmodule

`default_nettype wire

@@ rtl/core/krrl_engine.sv @@
// limiter state and its combinational next-state update for one event
// depends on krrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module krrl_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  krrl_pkg::krrl_cfg_t    cfg,
  input  logic                   fire,
  input  krrl_pkg::krrl_event_t  ev,
  output krrl_pkg::krrl_result_t res_nxt
);

  logic                        pend_imm_r,    pend_imm_nxt;
  logic                        pend_def_r,    pend_def_nxt;
  logic [krrl_pkg::TIME_W-1:0] last_grant_r,  last_grant_nxt;
  logic                        has_grant_r,   has_grant_nxt;
  logic [krrl_pkg::TIME_W-1:0] first_loss_r,  first_loss_nxt;
  logic                        has_loss_r,    has_loss_nxt;
  logic                        await_key_r,   await_key_nxt;
  logic [krrl_pkg::CNT_W-1:0]  req_cnt_r,     req_cnt_nxt;
  logic [krrl_pkg::CNT_W-1:0]  recv_cnt_r,    recv_cnt_nxt;
  logic [krrl_pkg::CNT_W-1:0]  acc_cnt_r,     acc_cnt_nxt;
  logic [krrl_pkg::CNT_W-1:0]  def_cnt_r,     def_cnt_nxt;
  logic [krrl_pkg::TIME_W-1:0] loss_delay_r,  loss_delay_nxt;
  logic                        loss_ok_r,     loss_ok_nxt;
  logic [krrl_pkg::TIME_W-1:0] frame_delay_r, frame_delay_nxt;
  logic                        frame_ok_r,    frame_ok_nxt;
  logic                        grant;

  logic [krrl_pkg::TIME_W-1:0] since_grant;
  logic                        too_soon;
  krrl_pkg::krrl_op_t          op;

  // wrapping time since last grant, against the zero-extended interval
  assign since_grant = ev.now_ms - last_grant_r;
  assign too_soon    = since_grant <
                       {{(krrl_pkg::TIME_W-krrl_pkg::INTERVAL_W){1'b0}}, cfg.min_interval_ms};
  assign op          = krrl_pkg::krrl_op_t'(ev.operation);

  // next state for the event in hand
  always_comb begin
    pend_imm_nxt    = pend_imm_r;
    pend_def_nxt    = pend_def_r;
    last_grant_nxt  = last_grant_r;
    has_grant_nxt   = has_grant_r;
    first_loss_nxt  = first_loss_r;
    has_loss_nxt    = has_loss_r;
    await_key_nxt   = await_key_r;
    req_cnt_nxt     = req_cnt_r;
    recv_cnt_nxt    = recv_cnt_r;
    acc_cnt_nxt     = acc_cnt_r;
    def_cnt_nxt     = def_cnt_r;
    loss_delay_nxt  = loss_delay_r;
    loss_ok_nxt     = loss_ok_r;
    frame_delay_nxt = frame_delay_r;
    frame_ok_nxt    = frame_ok_r;
    grant           = 1'b0;

    if (fire && cfg.enabled) begin
      unique case (op)
        // loss report: serve, merge or defer
        krrl_pkg::OP_LOSS: begin
          recv_cnt_nxt = recv_cnt_r + 1'b1;
          if (!has_loss_r) begin
            first_loss_nxt = ev.now_ms;
            has_loss_nxt   = 1'b1;
          end
          if (pend_imm_r) begin
            def_cnt_nxt = def_cnt_r + 1'b1;
          end else if (has_grant_r && too_soon) begin
            pend_def_nxt = 1'b1;
            def_cnt_nxt  = def_cnt_r + 1'b1;
          end else begin
            pend_imm_nxt = 1'b1;
            req_cnt_nxt  = req_cnt_r + 1'b1;
            acc_cnt_nxt  = acc_cnt_r + 1'b1;
          end
        end
        // new viewer or timeout: immediate request unless one is pending
        krrl_pkg::OP_NEW_VIEWER, krrl_pkg::OP_TIMEOUT: begin
          if (!pend_imm_r) begin
            pend_imm_nxt = 1'b1;
            pend_def_nxt = 1'b0;
            req_cnt_nxt  = req_cnt_r + 1'b1;
          end
        end
        // encoder poll: immediate wins, else a deferred one once due
        krrl_pkg::OP_POLL: begin
          if (pend_imm_r || (pend_def_r && !too_soon)) begin
            grant          = 1'b1;
            pend_imm_nxt   = 1'b0;
            pend_def_nxt   = 1'b0;
            last_grant_nxt = ev.now_ms;
            has_grant_nxt  = 1'b1;
            await_key_nxt  = 1'b1;
            if (has_loss_r) begin
              loss_delay_nxt = ev.now_ms - first_loss_r;
              loss_ok_nxt    = 1'b1;
              has_loss_nxt   = 1'b0;
            end
            if (!pend_imm_r) begin
              req_cnt_nxt = req_cnt_r + 1'b1;
            end
          end
        end
        // video frame: measure grant to key frame
        krrl_pkg::OP_FRAME: begin
          if (ev.key_frame && await_key_r) begin
            frame_delay_nxt = since_grant;
            frame_ok_nxt    = 1'b1;
            await_key_nxt   = 1'b0;
          end
        end
        default: begin
          grant = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_imm_r    <= 1'b0;
      pend_def_r    <= 1'b0;
      last_grant_r  <= '0;
      has_grant_r   <= 1'b0;
      first_loss_r  <= '0;
      has_loss_r    <= 1'b0;
      await_key_r   <= 1'b0;
      req_cnt_r     <= '0;
      recv_cnt_r    <= '0;
      acc_cnt_r     <= '0;
      def_cnt_r     <= '0;
      loss_delay_r  <= '0;
      loss_ok_r     <= 1'b0;
      frame_delay_r <= '0;
      frame_ok_r    <= 1'b0;
    end else begin
      pend_imm_r    <= pend_imm_nxt;
      pend_def_r    <= pend_def_nxt;
      last_grant_r  <= last_grant_nxt;
      has_grant_r   <= has_grant_nxt;
      first_loss_r  <= first_loss_nxt;
      has_loss_r    <= has_loss_nxt;
      await_key_r   <= await_key_nxt;
      req_cnt_r     <= req_cnt_nxt;
      recv_cnt_r    <= recv_cnt_nxt;
      acc_cnt_r     <= acc_cnt_nxt;
      def_cnt_r     <= def_cnt_nxt;
      loss_delay_r  <= loss_delay_nxt;
      loss_ok_r     <= loss_ok_nxt;
      frame_delay_r <= frame_delay_nxt;
      frame_ok_r    <= frame_ok_nxt;
    end
  end

  // result reports the state after the update
  always_comb begin
    res_nxt.grant                = grant;
    res_nxt.pending_now          = pend_imm_nxt;
    res_nxt.pending_later        = pend_def_nxt;
    res_nxt.request_count        = req_cnt_nxt;
    res_nxt.loss_received_count  = recv_cnt_nxt;
    res_nxt.loss_accepted_count  = acc_cnt_nxt;
    res_nxt.loss_deferred_count  = def_cnt_nxt;
    res_nxt.loss_to_grant_ms     = loss_delay_nxt;
    res_nxt.loss_to_grant_valid  = loss_ok_nxt;
    res_nxt.grant_to_frame_ms    = frame_delay_nxt;
    res_nxt.grant_to_frame_valid = frame_ok_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/krrl_out_stage.sv @@
// result register: holds one result request until the receiver takes it
// depends on krrl_pkg and krrl_out_if
`timescale 1ns / 1ps
`default_nettype none

module krrl_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  krrl_pkg::krrl_result_t res_nxt,
  output logic                   free,
  krrl_out_if.source             out_res
);

  logic                   valid_r;
  logic                   valid_nxt;
  krrl_pkg::krrl_result_t res_r;

  // a new result may load when empty or when the current one is taken
  assign free = !valid_r || out_res.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid                = valid_r;
  assign out_res.grant                = res_r.grant;
  assign out_res.pending_now          = res_r.pending_now;
  assign out_res.pending_later        = res_r.pending_later;
  assign out_res.request_count        = res_r.request_count;
  assign out_res.loss_received_count  = res_r.loss_received_count;
  assign out_res.loss_accepted_count  = res_r.loss_accepted_count;
  assign out_res.loss_deferred_count  = res_r.loss_deferred_count;
  assign out_res.loss_to_grant_ms     = res_r.loss_to_grant_ms;
  assign out_res.loss_to_grant_valid  = res_r.loss_to_grant_valid;
  assign out_res.grant_to_frame_ms    = res_r.grant_to_frame_ms;
  assign out_res.grant_to_frame_valid = res_r.grant_to_frame_valid;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the key frame request rate limiter
// holds a status tracker that predicts every result, plus drivers and monitors
// depends on krrl_pkg, the krrl channel interfaces and keyframe_request_rate_limiter_unit
`timescale 1ns / 1ps

package keyframe_tb_pkg;
  import krrl_pkg::*;

  // predicts the status returned for each event and checks what comes back
  class keyframe_status_tracker;
    bit                  en;
    bit [INTERVAL_W-1:0] interval_ms;

    bit              pend_now;
    bit              pend_later;
    bit              have_grant;
    bit              have_loss;
    bit              await_key;
    bit [TIME_W-1:0] last_grant_ms;
    bit [TIME_W-1:0] first_loss_ms;
    bit [CNT_W-1:0]  n_req;
    bit [CNT_W-1:0]  n_recv;
    bit [CNT_W-1:0]  n_acc;
    bit [CNT_W-1:0]  n_def;
    bit [TIME_W-1:0] loss_lat_ms;
    bit              loss_lat_ok;
    bit [TIME_W-1:0] frame_lat_ms;
    bit              frame_lat_ok;

    krrl_result_t expected_status[$];
    int unsigned  fail_count;

    function new();
      en          = 1'b0;
      interval_ms = MIN_INTERVAL_RESET;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_IDX_ENABLED:      en = value[0];
        CFG_IDX_MIN_INTERVAL: interval_ms = value[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    // a poll that grants an idr
    function void mark_grant(bit [TIME_W-1:0] t);
      last_grant_ms = t;
      have_grant    = 1'b1;
      await_key     = 1'b1;
      if (have_loss) begin
        loss_lat_ms = t - first_loss_ms;
        loss_lat_ok = 1'b1;
        have_loss   = 1'b0;
      end
    endfunction

    function void note_event(logic [OP_W-1:0] op, logic [TIME_W-1:0] t, logic key);
      bit [TIME_W-1:0] since_grant;
      bit              granted;
      krrl_result_t    st;
      since_grant = t - last_grant_ms;
      granted     = 1'b0;
      if (en) begin
        case (op)
          OP_LOSS: begin
            n_recv++;
            if (!have_loss) begin
              first_loss_ms = t;
              have_loss     = 1'b1;
            end
            if (pend_now) begin
              // merged into the pending immediate request
              n_def++;
            end else if (have_grant && since_grant < interval_ms) begin
              pend_later = 1'b1;
              n_def++;
            end else begin
              pend_now = 1'b1;
              n_req++;
              n_acc++;
            end
          end
          OP_NEW_VIEWER, OP_TIMEOUT: begin
            if (!pend_now) begin
              pend_now   = 1'b1;
              pend_later = 1'b0;
              n_req++;
            end
          end
          OP_POLL: begin
            // immediate wins; it was already counted when requested
            if (pend_now) begin
              pend_now   = 1'b0;
              pend_later = 1'b0;
              mark_grant(t);
              granted = 1'b1;
            end else if (pend_later && since_grant >= interval_ms) begin
              pend_later = 1'b0;
              mark_grant(t);
              n_req++;
              granted = 1'b1;
            end
          end
          OP_FRAME: begin
            if (key && await_key) begin
              frame_lat_ms = t - last_grant_ms;
              frame_lat_ok = 1'b1;
              await_key    = 1'b0;
            end
          end
          default: ;
        endcase
      end
      st = {granted, pend_now, pend_later, n_req, n_recv, n_acc, n_def,
            loss_lat_ms, loss_lat_ok, frame_lat_ms, frame_lat_ok};
      expected_status = {expected_status, st};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_status(krrl_result_t got);
      krrl_result_t want;
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("status with nothing expected: expected none, got %h", got);
        return;
      end
      want = expected_status.pop_front();
      compare_field("grant", want.grant, got.grant);
      compare_field("pending_now", want.pending_now, got.pending_now);
      compare_field("pending_later", want.pending_later, got.pending_later);
      compare_field("request_count", want.request_count, got.request_count);
      compare_field("loss_received_count", want.loss_received_count,
                    got.loss_received_count);
      compare_field("loss_accepted_count", want.loss_accepted_count,
                    got.loss_accepted_count);
      compare_field("loss_deferred_count", want.loss_deferred_count,
                    got.loss_deferred_count);
      compare_field("loss_to_grant_ms", want.loss_to_grant_ms, got.loss_to_grant_ms);
      compare_field("loss_to_grant_valid", want.loss_to_grant_valid,
                    got.loss_to_grant_valid);
      compare_field("grant_to_frame_ms", want.grant_to_frame_ms, got.grant_to_frame_ms);
      compare_field("grant_to_frame_valid", want.grant_to_frame_valid,
                    got.grant_to_frame_valid);
    endfunction

    function int unsigned outstanding();
      return expected_status.size();
    endfunction
  endclass
endpackage

module testbench;
  import krrl_pkg::*;
  import keyframe_tb_pkg::*;

  localparam int unsigned     STALL_LIMIT     = 2000;
  localparam int unsigned     HOLD_OFF_CYCLES = 80;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_FRAME + 1'b1;
  localparam logic [OP_W-1:0] OP_LAST_CODE    = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

  logic clk;
  logic rst_n;

  krrl_in_if  in_req ();
  krrl_out_if out_res ();
  krrl_cfg_if cfg_wr ();

  keyframe_request_rate_limiter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  keyframe_status_tracker tracker = new();

  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     cur_interval;
  bit [TIME_W-1:0] wall_ms;
  logic            hold_req;
  int unsigned     hold_left;
  int unsigned     quiet_cycles;
  krrl_result_t    seen;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on demand
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req      <= 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
      out_res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  // monitors: note each accepted event, check each accepted status
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_req.valid && in_req.ready)
        tracker.note_event(in_req.operation, in_req.now_ms, in_req.key_frame);
      if (out_res.valid && out_res.ready) begin
        seen = {out_res.grant, out_res.pending_now, out_res.pending_later,
                out_res.request_count, out_res.loss_received_count,
                out_res.loss_accepted_count, out_res.loss_deferred_count,
                out_res.loss_to_grant_ms, out_res.loss_to_grant_valid,
                out_res.grant_to_frame_ms, out_res.grant_to_frame_valid};
        tracker.check_status(seen);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one event request, with an optional idle gap ahead of it
  task automatic offer_event(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                             input logic key);
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.now_ms    <= t;
    in_req.key_frame <= key;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    do @(posedge clk); while (!cfg_wr.ready);
    tracker.write_register(idx, value);
    cfg_wr.valid <= 1'b0;
    @(posedge clk);
  endtask

  // step past the last accept edge so its request is noted before counting
  task automatic wait_for_results();
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // new settings, written only once the block has gone quiet
  task automatic configure(input bit en, input logic [INTERVAL_W-1:0] iv,
                           input int unsigned idle, input int unsigned stall);
    logic [CFG_DATA_W-1:0] en_word;
    in_req.valid <= 1'b0;
    wait_for_results();
    en_word    = CFG_DATA_W'($urandom);
    en_word[0] = en;
    write_reg(CFG_IDX_ENABLED, en_word);
    write_reg(CFG_IDX_MIN_INTERVAL, iv);
    cur_interval = iv;
    idle_pct     = idle;
    stall_pct    = stall;
  endtask

  // mostly plausible event streams on a running clock, some pure noise
  task automatic random_events(input int unsigned count);
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] t;
    logic              key;
    int unsigned       pick;
    repeat (count) begin
      pick = $urandom_range(1, 100);
      if (pick <= 85) begin
        if ($urandom_range(1, 50) == 1)
          wall_ms += $urandom;
        else
          wall_ms += $urandom_range(0, 2 * cur_interval + 4);
        pick = $urandom_range(1, 100);
        if (pick <= 35)      op = OP_LOSS;
        else if (pick <= 70) op = OP_POLL;
        else if (pick <= 90) op = OP_FRAME;
        else if (pick <= 95) op = OP_NEW_VIEWER;
        else                 op = OP_TIMEOUT;
        t   = wall_ms;
        key = ($urandom_range(1, 10) <= 7);
      end else begin
        op  = OP_W'($urandom_range(0, OP_LAST_CODE));
        t   = $urandom;
        key = 1'($urandom_range(0, 1));
      end
      offer_event(op, t, key);
    end
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_req.valid     = 1'b0;
    in_req.operation = OP_LOSS;
    in_req.now_ms    = '0;
    in_req.key_frame = 1'b0;
    out_res.ready    = 1'b0;
    cfg_wr.valid     = 1'b0;
    cfg_wr.index     = CFG_IDX_ENABLED;
    cfg_wr.data      = '0;
    hold_req         = 1'b0;
    hold_left        = 0;
    quiet_cycles     = 0;
    idle_pct         = 0;
    stall_pct        = 0;
    cur_interval     = MIN_INTERVAL_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset: events leave the state alone
    offer_event(OP_LOSS, 32'd100, 1'b0);
    offer_event(OP_POLL, 32'd200, 1'b1);
    in_req.valid <= 1'b0;
    wait_for_results();

    // enable only, interval stays at its reset value
    write_reg(CFG_IDX_ENABLED, 16'd1);
    offer_event(OP_POLL, 32'd0, 1'b0);           // nothing pending
    offer_event(OP_FRAME, 32'd10, 1'b1);         // key frame with no grant awaited
    offer_event(OP_LOSS, 32'd1000, 1'b0);        // first loss, served at once
    offer_event(OP_LOSS, 32'd1001, 1'b0);        // merged into the immediate one
    offer_event(OP_NEW_VIEWER, 32'd1002, 1'b0);  // repeat while pending
    offer_event(OP_POLL, 32'd1500, 1'b0);
    offer_event(OP_FRAME, 32'd1600, 1'b0);       // non-key frame
    offer_event(OP_FRAME, 32'd1700, 1'b1);
    offer_event(OP_LOSS, 32'd2000, 1'b0);        // inside interval, deferred
    offer_event(OP_POLL, 32'd2499, 1'b0);        // one ms short
    offer_event(OP_POLL, 32'd2500, 1'b0);        // exactly due
    offer_event(OP_TIMEOUT, 32'd2600, 1'b0);
    offer_event(OP_LOSS, 32'd2700, 1'b0);
    offer_event(OP_POLL, 32'd2900, 1'b1);
    offer_event(OP_FIRST_UNUSED, 32'd2950, 1'b1);
    offer_event(OP_LAST_CODE, 32'd2960, 1'b0);
    offer_event(OP_LOSS, 32'hFFFF_FF00, 1'b1);   // timestamps wrap from here
    offer_event(OP_POLL, 32'h0000_0010, 1'b0);
    offer_event(OP_LOSS, 32'h0000_0020, 1'b0);
    offer_event(OP_NEW_VIEWER, 32'h0000_0021, 1'b0);  // clears the deferred one
    offer_event(OP_POLL, 32'hFFFF_FFFF, 1'b0);

    // zero interval: loss never deferred
    configure(1'b1, 16'd0, 0, 0);
    offer_event(OP_LOSS, 32'd5, 1'b0);
    offer_event(OP_POLL, 32'd5, 1'b0);
    offer_event(OP_LOSS, 32'd5, 1'b0);

    // random phases over several settings and idling mixes
    wall_ms = $urandom;
    configure(1'b1, 16'd20, 0, 0);
    random_events(170);
    configure(1'b1, 16'hFFFF, 46, 0);
    random_events(170);
    configure(1'b1, 16'd0, 0, 46);
    random_events(170);

    configure(1'b1, 16'd100, 20, 20);
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
    random_events(30);
    hold_req <= 1'b1;
    random_events(140);

    configure(1'b0, 16'd500, 46, 46);
    random_events(40);

    configure(1'b1, INTERVAL_W'($urandom_range(1, 300)), 0, 0);
    random_events(90);
    in_req.valid <= 1'b0;
    wait_for_results();
    random_events(90);

    in_req.valid <= 1'b0;
    wait_for_results();
    if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
